>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent in one cycle requires consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pao_pkg.sv
// package: widths, codes and sine table builder for the phase accumulator oscillator
`timescale 1ns / 1ps

package pao_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   // fixed field widths
   localparam int INC_BITS   = 32;
   localparam int WIDTH_BITS = 16;
   localparam int AMP_BITS   = 16;
   localparam int AMP_FRAC   = 15;
   localparam int WAVE_BITS  = 3;

   // derived widths
   localparam int FULL      = 1 << (SAMPLE_BITS - 1);
   localparam int SHAPE_W   = SAMPLE_BITS + 1;
   localparam int TRI_W     = SAMPLE_BITS + 2;
   localparam int PROD_W    = SHAPE_W + AMP_BITS + 1;
   localparam int EXT_W     = (PHASE_BITS > SAMPLE_BITS + 1) ? PHASE_BITS : SAMPLE_BITS + 1;
   localparam int INC_EXT_W = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;
   localparam int ROM_N     = 1 << SINE_TABLE_BITS;
   localparam int ROM_DEPTH = ROM_N + 1;
   localparam int ROM_AW    = SINE_TABLE_BITS + 1;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // shape codes
   localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
   localparam logic [WAVE_BITS-1:0] WAVE_SAW      = 3'd3;
   localparam logic [WAVE_BITS-1:0] WAVE_PULSE    = 3'd4;

   // register indexes
   localparam logic CSR_WAVEFORM  = 1'b0;
   localparam logic CSR_AMPLITUDE = 1'b1;

   localparam logic [AMP_BITS-1:0] AMP_RESET = 16'd32768;

   // entries reach full scale at the quarter-wave peak, so one bit above the sample width
   typedef logic [SAMPLE_BITS:0] sine_rom_type [ROM_DEPTH];

   // truncating shift-subtract division, used only while building the table
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = 0;
      rem = 0;
      for (b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 64'd1);
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // quarter-wave table from a fixed-point taylor series, evaluated at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          sum;
      longint unsigned sum_u;
      int              i;
      int              k;
      for (i = 0; i < ROM_DEPTH; i++) begin
         x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (k = 1; k <= 7; k++) begin
            div  = longint'((2 * k) * (2 * k + 1));
            term = udiv((term * x2) >> 30, div);
            if (k[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         sum_u  = longint'(sum);
         rom[i] = (SAMPLE_BITS + 1)'(((sum_u << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30);
      end
      return rom;
   endfunction

endpackage

>>> rtl/phase_accumulator_waveform_oscillator.sv
// top level: phase accumulator oscillator with sine, triangle, square, saw and pulse shapes
`timescale 1ns / 1ps

// Each word accepted on the req_ channel asks for one sample. The sample is formed from the
// phase held before that word (sine from a quarter-wave table, triangle, square, saw or
// pulse), scaled by the amplitude register with round-half-up and saturated to a signed
// SAMPLE_BITS value; then the phase advances by the word's increment modulo one cycle and
// rsp_cycle_wrapped flags the wrap. One word is taken every clock cycle unless rsp_ready
// stalls a full pipeline; a word passes the shape/table read, multiply and output registers
// before rsp_valid rises, and the stages fill bubbles, so req_ready stays high while the
// output waits as long as an earlier stage is free. The phase register is updated at
// acceptance, so words follow back to back. The user must write waveform and amplitude
// through csr_ only while idle, which the block does not check; codes 5 to 7 give sample 0.

`include "assert_macros.svh"

module phase_accumulator_waveform_oscillator
   import pao_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // request words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [INC_BITS-1:0]           req_phase_increment,
   input  logic [WIDTH_BITS-1:0]         req_pulse_width,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_cycle_wrapped,
   // register writes
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [AMP_BITS-1:0]           csr_write_data
);

   localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1 << (AMP_FRAC - 1));
   localparam logic signed [PROD_W:0] SAT_MAX    = (PROD_W + 1)'(FULL - 1);
   localparam logic signed [PROD_W:0] SAT_MIN    = -((PROD_W + 1)'(FULL));

   // configuration
   logic [WAVE_BITS-1:0]          wave_ff;
   logic [AMP_BITS-1:0]           amp_ff;

   // phase state
   logic [PHASE_BITS-1:0]         phase_ff;
   logic [PHASE_BITS-1:0]         inc;
   logic [INC_EXT_W-1:0]          inc_ext;
   logic [PHASE_BITS:0]           phase_sum;

   // stage valids and carried wrap flags
   logic                          s1_valid_ff;
   logic                          s2_valid_ff;
   logic                          rsp_valid_ff;
   logic                          s1_wrap_ff;
   logic                          s2_wrap_ff;
   logic                          rsp_wrap_ff;

   // datapath
   logic signed [SHAPE_W-1:0]     shape;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W:0]        rounded;
   logic signed [PROD_W:0]        scaled;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   // stall control: each stage moves when the one after it is empty or moving
   logic                          out_en;
   logic                          s2_en;
   logic                          s1_en;
   logic                          req_accept;

   assign out_en     = ~rsp_valid_ff | rsp_ready;
   assign s2_en      = ~s2_valid_ff | out_en;
   assign s1_en      = ~s1_valid_ff | s2_en;
   assign req_ready  = s1_en;
   assign req_accept = req_valid & req_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= WAVE_SINE;
         amp_ff  <= AMP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WAVEFORM:  wave_ff <= csr_write_data[WAVE_BITS-1:0];
            CSR_AMPLITUDE: amp_ff  <= csr_write_data;
            default:       wave_ff <= wave_ff;
         endcase
      end
   end

   // align the q0.32 increment to the phase width
   assign inc_ext   = INC_EXT_W'(req_phase_increment) << (INC_EXT_W - INC_BITS);
   assign inc       = inc_ext[INC_EXT_W-1 -: PHASE_BITS];
   assign phase_sum = {1'b0, phase_ff} + {1'b0, inc};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_sum[PHASE_BITS-1:0];
      end
   end

   // stage 1: shape value from the phase before the advance
   pao_shape u_shape (
      .clock       (clock),
      .load        (req_accept),
      .phase       (phase_ff),
      .waveform    (wave_ff),
      .pulse_width (req_pulse_width),
      .shape       (shape)
   );

   // stage 2: gain multiply, both operands sign-extended to the product width
   assign prod_in = PROD_W'(shape) * PROD_W'($signed({1'b0, amp_ff}));

   // stage 3: round half up, drop q15 fraction, saturate
   assign rounded = $signed({prod_ff[PROD_W-1], prod_ff}) + ROUND_HALF;
   assign scaled  = rounded >>> AMP_FRAC;

   always_comb begin
      priority if (scaled > SAT_MAX) begin
         sample_in = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (scaled < SAT_MIN) begin
         sample_in = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sample_in = scaled[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_accept;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_wrap_ff <= phase_sum[PHASE_BITS];
      end
      if (s2_en && s1_valid_ff) begin
         prod_ff    <= prod_in;
         s2_wrap_ff <= s1_wrap_ff;
      end
      if (out_en && s2_valid_ff) begin
         sample_ff   <= sample_in;
         rsp_wrap_ff <= s2_wrap_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = sample_ff;
   assign rsp_cycle_wrapped = rsp_wrap_ff;

   // phase moves only when a word is taken
   `ASSERT_NEXT(a_phase_hold, !req_accept, $stable(phase_ff), "phase changed without a word")
   // an accepted word always lands in stage 1
   `ASSERT_NEXT(a_s1_fill, req_accept, s1_valid_ff, "accepted word lost before stage 1")
   // a stalled output keeps the multiply stage occupied
   `ASSERT_NEXT(a_s2_hold, s2_valid_ff && rsp_valid_ff && !rsp_ready, s2_valid_ff,
      "multiply stage dropped a word under stall")

endmodule

>>> rtl/pao_shape.sv
// waveform shape generator: sine rom read and naive shapes, one register stage
`timescale 1ns / 1ps

module pao_shape
   import pao_pkg::*;
(
   input  logic                        clock,
   input  logic                        load,
   input  logic [PHASE_BITS-1:0]       phase,
   input  logic [WAVE_BITS-1:0]        waveform,
   input  logic [WIDTH_BITS-1:0]       pulse_width,
   output logic signed [SHAPE_W-1:0]   shape
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   localparam logic signed [SHAPE_W-1:0] FULL_S     = SHAPE_W'(FULL);
   localparam logic signed [TRI_W-1:0]   FULL_T     = TRI_W'(FULL);
   localparam logic signed [TRI_W-1:0]   THREE_FULL = TRI_W'(3 * FULL);

   logic [EXT_W-1:0]             ph_ext;
   logic [SINE_TABLE_BITS+1:0]   sine_top;
   logic [1:0]                   quad;
   logic [ROM_AW-1:0]            idx;
   logic [ROM_AW-1:0]            rom_addr;
   logic [SAMPLE_BITS:0]         tri_a;
   logic [SAMPLE_BITS-1:0]       saw_a;
   logic signed [TRI_W-1:0]      tri_v;
   logic signed [SHAPE_W-1:0]    saw_v;
   logic [PHASE_BITS-1:0]        width_al;
   logic                         first_half;
   logic signed [SHAPE_W-1:0]    alt_in;
   logic signed [SHAPE_W-1:0]    rom_s;

   logic [SAMPLE_BITS:0]         rom_data_ff;
   logic signed [SHAPE_W-1:0]    alt_ff;
   logic                         neg_ff;
   logic                         is_sine_ff;

   assign ph_ext     = EXT_W'(phase) << (EXT_W - PHASE_BITS);
   assign first_half = ~phase[PHASE_BITS-1];

   // quadrant and mirrored table index
   assign sine_top = phase[PHASE_BITS-1 -: SINE_TABLE_BITS + 2];
   assign quad     = sine_top[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
   assign idx      = {1'b0, sine_top[SINE_TABLE_BITS-1:0]};
   assign rom_addr = quad[0] ? (ROM_AW'(ROM_N) - idx) : idx;

   assign tri_a    = ph_ext[EXT_W-1 -: SAMPLE_BITS + 1];
   assign saw_a    = ph_ext[EXT_W-1 -: SAMPLE_BITS];
   assign tri_v    = first_half ? ($signed({1'b0, tri_a}) - FULL_T)
                                : (THREE_FULL - $signed({1'b0, tri_a}));
   assign saw_v    = $signed({1'b0, saw_a}) - FULL_S;
   assign width_al = PHASE_BITS'(pulse_width) << (PHASE_BITS - WIDTH_BITS);

   always_comb begin
      unique case (waveform)
         WAVE_SINE:     alt_in = '0;
         WAVE_TRIANGLE: alt_in = $signed(tri_v[SHAPE_W-1:0]);
         WAVE_SQUARE:   alt_in = first_half ? FULL_S : -FULL_S;
         WAVE_SAW:      alt_in = saw_v;
         WAVE_PULSE:    alt_in = (phase < width_al) ? FULL_S : -FULL_S;
         default:       alt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rom_data_ff <= SINE_ROM[rom_addr];
         alt_ff      <= alt_in;
         neg_ff      <= quad[1];
         is_sine_ff  <= (waveform == WAVE_SINE);
      end
   end

   // table entries never exceed full scale, so the top bit reads as a positive value
   assign rom_s = $signed(rom_data_ff);
   assign shape = is_sine_ff ? (neg_ff ? -rom_s : rom_s) : alt_ff;

endmodule
